[rtl/pna_pkg.sv]
// Package for the padded number to ASCII block: sizes, mode codes, ASCII
// constants and the controller state type. Depends on nothing.
package pna_pkg;

    localparam int VALUE_BITS  = 64;
    localparam int WIDTH_LIMIT = 63;
    // Decimal digits needed for VALUE_BITS bits (log10(2) ~ 0.30103).
    localparam int BCD_DIGITS  = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int BCD_BITS    = 4 * BCD_DIGITS;
    localparam int PTR_DIGITS  = (VALUE_BITS + 3) / 4;
    localparam int HEX_DIGITS  = 8;
    localparam int CNT_W       = $clog2(VALUE_BITS + 1);
    localparam int REM_W       = $clog2(BCD_DIGITS + 1);
    localparam int LEN_W       = 7;

    localparam logic [2:0] MODE_SDEC = 3'd0;
    localparam logic [2:0] MODE_UDEC = 3'd1;
    localparam logic [2:0] MODE_LHEX = 3'd2;
    localparam logic [2:0] MODE_UHEX = 3'd3;
    localparam logic [2:0] MODE_PTR  = 3'd4;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_UA    = 8'h41;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_SETUP,
        ST_EMIT
    } state_t;

endpackage

[rtl/pna_bcd.sv]
// Bit-serial binary to BCD converter (shift and add three), one bit per cycle.
// Depends on pna_pkg.
module pna_bcd (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  logic [pna_pkg::VALUE_BITS-1:0] bin,
    output logic                           busy,
    output logic [pna_pkg::BCD_BITS-1:0]   bcd
);
    import pna_pkg::*;

    logic [VALUE_BITS-1:0] bin_reg, bin_next;
    logic [BCD_BITS-1:0]   bcd_reg, bcd_next;
    logic [BCD_BITS-1:0]   adj;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;

    // Every digit of five or more is corrected before the shift.
    always_comb
    begin
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ? bcd_reg[4*i +: 4] + 4'd3
                                                        : bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (load)
        begin
            bin_next  = bin;
            bcd_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            {bcd_next, bin_next} = {adj[BCD_BITS-2:0], bin_reg, 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(VALUE_BITS - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign busy = busy_reg;
    assign bcd  = bcd_reg;

endmodule

[rtl/padded_number_to_ascii.sv]
// Top level of the padded number to ASCII formatter.
// Depends on pna_pkg and pna_bcd.
//
// Usage: an item is transferred when start is high and busy is low. The
// fields give the mode, the 64-bit value and the formatting options. The
// block then emits one ASCII character per cycle on char_out, marked by
// strobe, with last high on the final character. When nothing can be
// emitted, one strobe carries empty_res and last with char_out zero.
// Steps: decimal modes wait on the serial BCD converter, which shifts in one
// bit per cycle, then scan past leading zero digits and pass a setup state
// before the first character; hex and pointer modes skip the converter but
// still scan and set up. Characters then follow one per cycle until the
// item's character count is reached.
// busy stays high from the transfer until the cycle after the last strobe.
// The receiver cannot stall: every strobe is a transfer. Reset returns the
// controller to idle; no item is in flight afterwards.
module padded_number_to_ascii (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  mode,
    input  logic [63:0] value,
    input  logic [5:0]  field_width,
    input  logic        zero_pad,
    input  logic        left_align,
    input  logic        add_prefix,
    input  logic [11:0] space_left,
    output logic        strobe,
    output logic [7:0]  char_out,
    output logic        last,
    output logic        empty_res
);
    import pna_pkg::*;

    state_t state_reg, state_next;

    logic [2:0]          mode_reg, mode_next;
    logic                neg_reg, neg_next;
    logic [5:0]          w_reg, w_next;
    logic                zp_reg, zp_next;
    logic                la_reg, la_next;
    logic                pre_reg, pre_next;
    logic [11:0]         room_reg, room_next;
    logic [BCD_BITS-1:0] dig_reg, dig_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [LEN_W-1:0]    b1_reg, b1_next, b2_reg, b2_next, b3_reg, b3_next;
    logic [LEN_W-1:0]    b4_reg, b4_next, b5_reg, b5_next;
    logic [LEN_W-1:0]    n_reg, n_next, pos_reg, pos_next;
    logic                empty_reg, empty_next;
    logic [7:0]          padc_reg, padc_next;

    logic                  accept;
    logic [VALUE_BITS-1:0] vmask, mag;
    logic                  in_neg;
    logic                  bcd_busy;
    logic [BCD_BITS-1:0]   bcd;

    logic                  is_dec, is_hex, is_ptr, upper, sgn;
    logic [5:0]            w_sat;
    logic [LEN_W-1:0]      nd, pre_len, base, pad, pad_a, pad_b, pad_c;
    logic [LEN_W-1:0]      s_b1, s_b2, s_b3, s_b4, s_b5, s_len;
    logic [3:0]            top;
    logic [7:0]            dig_char;
    logic                  in_digits;

    assign accept = start && (state_reg == ST_IDLE);
    assign vmask  = value[VALUE_BITS-1:0];
    assign in_neg = (mode == MODE_SDEC) && vmask[VALUE_BITS-1];
    assign mag    = in_neg ? (~vmask + 1'b1) : vmask;

    pna_bcd u_bcd (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (accept && (mode == MODE_SDEC || mode == MODE_UDEC)),
        .bin   (mag),
        .busy  (bcd_busy),
        .bcd   (bcd)
    );

    // Layout of the text: prefix, pad A, sign, zero pad, digits, trailing pad.
    always_comb
    begin
        is_dec  = (mode_reg == MODE_SDEC) || (mode_reg == MODE_UDEC);
        is_hex  = (mode_reg == MODE_LHEX) || (mode_reg == MODE_UHEX);
        is_ptr  = (mode_reg == MODE_PTR);
        upper   = (mode_reg == MODE_UHEX);
        sgn     = is_dec && neg_reg;
        w_sat   = (w_reg > 6'(WIDTH_LIMIT)) ? 6'(WIDTH_LIMIT) : w_reg;
        nd      = (is_dec || is_hex || is_ptr) ? LEN_W'(rem_reg) : '0;
        pre_len = ((is_hex && pre_reg) || is_ptr) ? LEN_W'(2) : '0;
        base    = nd + pre_len + LEN_W'(sgn);
        pad     = (LEN_W'(w_sat) > base) ? LEN_W'(w_sat) - base : '0;
        pad_a   = ((is_dec && !la_reg && !zp_reg) || is_hex) ? pad : '0;
        pad_b   = (is_dec && !la_reg && zp_reg) ? pad : '0;
        pad_c   = (is_dec && la_reg) ? pad : '0;
        s_b1    = pre_len;
        s_b2    = s_b1 + pad_a;
        s_b3    = s_b2 + LEN_W'(sgn);
        s_b4    = s_b3 + pad_b;
        s_b5    = s_b4 + nd;
        s_len   = s_b5 + pad_c;
    end

    assign top       = dig_reg[BCD_BITS-1 -: 4];
    assign dig_char  = (top < 4'd10) ? CH_ZERO + 8'(top)
                                     : (upper ? CH_UA : CH_LA) + 8'(top - 4'd10);
    assign in_digits = (pos_reg >= b4_reg) && (pos_reg < b5_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (mode == MODE_SDEC || mode == MODE_UDEC)
                    begin
                        state_next = ST_CONV;
                    end
                    else if (mode == MODE_LHEX || mode == MODE_UHEX || mode == MODE_PTR)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_CONV:
            begin
                if (!bcd_busy)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!(top == 4'd0 && rem_reg > REM_W'(1)))
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (empty_reg || (pos_reg + 1'b1 == n_reg))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath registers.
    always_comb
    begin
        mode_next  = mode_reg;
        neg_next   = neg_reg;
        w_next     = w_reg;
        zp_next    = zp_reg;
        la_next    = la_reg;
        pre_next   = pre_reg;
        room_next  = room_reg;
        dig_next   = dig_reg;
        rem_next   = rem_reg;
        b1_next    = b1_reg;
        b2_next    = b2_reg;
        b3_next    = b3_reg;
        b4_next    = b4_reg;
        b5_next    = b5_reg;
        n_next     = n_reg;
        pos_next   = pos_reg;
        empty_next = empty_reg;
        padc_next  = padc_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    mode_next = mode;
                    neg_next  = in_neg;
                    w_next    = field_width;
                    zp_next   = zero_pad;
                    la_next   = left_align;
                    pre_next  = add_prefix;
                    room_next = space_left;
                    rem_next  = REM_W'(1);
                    if (mode == MODE_PTR)
                    begin
                        dig_next = BCD_BITS'(vmask) << (BCD_BITS - 4 * PTR_DIGITS);
                        rem_next = REM_W'(PTR_DIGITS);
                    end
                    else
                    begin
                        dig_next = BCD_BITS'(value[31:0]) << (BCD_BITS - 4 * HEX_DIGITS);
                        rem_next = REM_W'(HEX_DIGITS);
                    end
                end
            end
            ST_CONV:
            begin
                dig_next = bcd;
                rem_next = REM_W'(BCD_DIGITS);
            end
            ST_SCAN:
            begin
                if (top == 4'd0 && rem_reg > REM_W'(1))
                begin
                    dig_next = dig_reg << 4;
                    rem_next = rem_reg - 1'b1;
                end
            end
            ST_SETUP:
            begin
                b1_next    = s_b1;
                b2_next    = s_b2;
                b3_next    = s_b3;
                b4_next    = s_b4;
                b5_next    = s_b5;
                n_next     = (12'(s_len) < room_reg) ? s_len : LEN_W'(room_reg);
                empty_next = (s_len == '0) || (room_reg == '0)
                             || (sgn && 12'(s_b2) >= room_reg);
                padc_next  = (is_hex && zp_reg) ? CH_ZERO : CH_SPACE;
                pos_next   = '0;
            end
            ST_EMIT:
            begin
                pos_next = pos_reg + 1'b1;
                if (in_digits)
                begin
                    dig_next = dig_reg << 4;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        strobe    = (state_reg == ST_EMIT);
        busy      = (state_reg != ST_IDLE);
        empty_res = strobe && empty_reg;
        last      = strobe && (empty_reg || (pos_reg + 1'b1 == n_reg));
        if (!strobe || empty_reg)
        begin
            char_out = 8'd0;
        end
        else if (pos_reg < b1_reg)
        begin
            char_out = !pos_reg[0] ? CH_ZERO : (upper ? CH_UX : CH_LX);
        end
        else if (pos_reg < b2_reg)
        begin
            char_out = padc_reg;
        end
        else if (pos_reg < b3_reg)
        begin
            char_out = CH_MINUS;
        end
        else if (pos_reg < b4_reg)
        begin
            char_out = CH_ZERO;
        end
        else if (in_digits)
        begin
            char_out = dig_char;
        end
        else
        begin
            char_out = CH_SPACE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        neg_reg   <= neg_next;
        w_reg     <= w_next;
        zp_reg    <= zp_next;
        la_reg    <= la_next;
        pre_reg   <= pre_next;
        room_reg  <= room_next;
        dig_reg   <= dig_next;
        rem_reg   <= rem_next;
        b1_reg    <= b1_next;
        b2_reg    <= b2_next;
        b3_reg    <= b3_next;
        b4_reg    <= b4_next;
        b5_reg    <= b5_next;
        n_reg     <= n_next;
        pos_reg   <= pos_next;
        empty_reg <= empty_next;
        padc_reg  <= padc_next;
    end

    // The transfer that ends an item frees the block in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) (strobe && last) |=> !busy)
        else $error("block still busy after the last character");

    // An empty result is the only result of its item and carries no character.
    assert property (@(posedge clk) disable iff (!rst_n)
        empty_res |-> (last && char_out == 8'd0))
        else $error("empty result carries a character or is not last");

    // Characters never run past the room the item allowed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !empty_res) |-> (12'(pos_reg) < room_reg))
        else $error("character emitted beyond the available space");

    // A transfer always starts work on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accepted item did not make the block busy");

endmodule

[tb/tb_padded_number_to_ascii.sv]
// Testbench for padded_number_to_ascii: predicts the formatted characters of
// each transferred number and checks every strobed character against them.
// Depends on pna_pkg and the padded_number_to_ascii RTL.
`timescale 1ns / 1ps

class char_scoreboard;
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       empty;
    } char_t;

    char_t pending[$];
    int    mismatches;

    // Digits of v in the given base, most significant first.
    function automatic string digits_of(logic [63:0] v, int base, bit upper);
        string s;
        int d;
        s = "";
        do begin
            d = int'(v % base);
            if (d < 10)
                s = {string'(byte'(8'h30 + d)), s};
            else
                s = {string'(byte'((upper ? 8'h41 : 8'h61) + d - 10)), s};
            v = v / base;
        end while (v != 0);
        return s;
    endfunction

    function automatic void note_item(logic [2:0] md, logic [63:0] v, logic [5:0] fw,
                                      bit zp, bit la, bit pre, logic [11:0] room);
        string txt, dg;
        int sign_at, pad, n;
        bit neg;
        txt = "";
        sign_at = -1;
        neg = 0;
        if (md == pna_pkg::MODE_SDEC || md == pna_pkg::MODE_UDEC) begin
            if (md == pna_pkg::MODE_SDEC && v[63]) begin
                neg = 1;
                v = -v;
            end
            dg = digits_of(v, 10, 0);
            pad = (fw > dg.len() + neg) ? fw - dg.len() - neg : 0;
            if (!la && zp) begin
                if (neg) begin
                    sign_at = 0;
                    txt = "-";
                end
                repeat (pad) txt = {txt, "0"};
            end else begin
                if (!la) repeat (pad) txt = {txt, " "};
                if (neg) begin
                    sign_at = txt.len();
                    txt = {txt, "-"};
                end
            end
            txt = {txt, dg};
            if (la) while (txt.len() < fw) txt = {txt, " "};
        end else if (md == pna_pkg::MODE_LHEX || md == pna_pkg::MODE_UHEX) begin
            dg = digits_of({32'd0, v[31:0]}, 16, md == pna_pkg::MODE_UHEX);
            if (pre) txt = (md == pna_pkg::MODE_UHEX) ? "0X" : "0x";
            pad = (fw > dg.len() + txt.len()) ? fw - dg.len() - txt.len() : 0;
            repeat (pad) txt = {txt, zp ? "0" : " "};
            txt = {txt, dg};
        end else if (md == pna_pkg::MODE_PTR) begin
            txt = {"0x", digits_of(v, 16, 0)};
        end
        n = (txt.len() < room) ? txt.len() : room;
        if (sign_at >= 0 && sign_at >= room) n = 0;
        if (n == 0) pending.push_back('{8'h00, 1'b1, 1'b1});
        for (int k = 0; k < n; k++)
            pending.push_back('{txt[k], k == n - 1, 1'b0});
    endfunction

    function automatic void check_char(logic [7:0] ch, logic lst, logic emp);
        char_t e;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected character %h", ch);
            return;
        end
        e = pending.pop_front();
        if (e.ch !== ch || e.last !== lst || e.empty !== emp) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected ch=%h last=%b empty=%b, got ch=%h last=%b empty=%b",
                         e.ch, e.last, e.empty, ch, lst, emp);
        end
    endfunction
endclass

module tb_padded_number_to_ascii;
    import pna_pkg::*;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic [2:0]  mode = '0;
    logic [63:0] value = '0;
    logic [5:0]  field_width = '0;
    logic        zero_pad = 0;
    logic        left_align = 0;
    logic        add_prefix = 0;
    logic [11:0] space_left = '0;
    logic        strobe;
    logic [7:0]  char_out;
    logic        last;
    logic        empty_res;

    char_scoreboard chars = new();

    padded_number_to_ascii u_top (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n && strobe) chars.check_char(char_out, last, empty_res);
    end

    // Presents one item and holds it until it is transferred.
    task automatic send_item(logic [2:0] md, logic [63:0] v, logic [5:0] fw,
                             bit zp, bit la, bit pre, logic [11:0] room);
        start       <= 1;
        mode        <= md;
        value       <= v;
        field_width <= fw;
        zero_pad    <= zp;
        left_align  <= la;
        add_prefix  <= pre;
        space_left  <= room;
        do @(posedge clk); while (busy);
        chars.note_item(md, v, fw, zp, la, pre, room);
    endtask

    task automatic pause_sender(int cycles);
        start <= 0;
        repeat (cycles) @(posedge clk);
    endtask

    function automatic logic [63:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 64'(1) << $urandom_range(0, 63);
            1: return -(64'($urandom_range(0, 1000)));
            2: return 64'($urandom_range(0, 99999));
            3: return {32'h0, $urandom()};
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    initial
    begin
        int burst;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // Directed: extremes, each mode, zero, sign cut off, zero room, bad modes.
        send_item(MODE_SDEC, 64'h8000_0000_0000_0000, 6'd63, 1, 0, 0, 12'd4095);
        send_item(MODE_SDEC, '1, 6'd5, 1, 0, 0, 12'd4095);
        send_item(MODE_SDEC, '1, 6'd5, 0, 0, 0, 12'd4);
        send_item(MODE_SDEC, '1, 6'd5, 0, 0, 0, 12'd3);
        send_item(MODE_SDEC, -64'd42, 6'd8, 0, 1, 1, 12'd4095);
        send_item(MODE_SDEC, 64'd0, 6'd0, 0, 0, 0, 12'd4095);
        send_item(MODE_UDEC, '1, 6'd0, 0, 0, 0, 12'd4095);
        send_item(MODE_UDEC, 64'd7, 6'd63, 0, 1, 0, 12'd4095);
        send_item(MODE_UDEC, 64'd12345, 6'd10, 1, 1, 0, 12'd7);
        send_item(MODE_LHEX, 64'hFFFF_FFFF_DEAD_BEEF, 6'd12, 1, 0, 1, 12'd4095);
        send_item(MODE_LHEX, 64'd0, 6'd4, 0, 1, 0, 12'd4095);
        send_item(MODE_UHEX, 64'h0000_0000_00AB_CDEF, 6'd12, 0, 0, 1, 12'd4095);
        send_item(MODE_UHEX, 64'hFFFF_FFFF, 6'd63, 1, 1, 1, 12'd1);
        send_item(MODE_PTR, '1, 6'd40, 1, 1, 1, 12'd4095);
        send_item(MODE_PTR, 64'd0, 6'd0, 0, 0, 0, 12'd4095);
        send_item(MODE_PTR, 64'h1234, 6'd0, 0, 0, 0, 12'd3);
        send_item(MODE_UDEC, 64'd99, 6'd3, 0, 0, 0, 12'd0);
        send_item(3'd5, 64'd1, 6'd3, 0, 0, 0, 12'd4095);
        send_item(3'd6, 64'd1, 6'd3, 0, 0, 0, 12'd4095);
        send_item(3'd7, 64'd1, 6'd3, 0, 0, 0, 12'd4095);
        // Random bursts of transfers, most of them followed by a random gap.
        for (int i = 0; i < 250; i += burst) begin
            burst = $urandom_range(1, 12);
            for (int j = 0; j < burst; j++)
                send_item(($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                                       : 3'($urandom_range(0, 4)),
                          rand_value(), 6'($urandom()), $urandom_range(0, 1),
                          $urandom_range(0, 1), $urandom_range(0, 1),
                          ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 70))
                                                      : 12'($urandom()));
            if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 40));
        end
        start <= 0;
        while (chars.pending.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (chars.mismatches == 0)
            $display("tb_padded_number_to_ascii: done, clean");
        else
            $display("tb_padded_number_to_ascii: done, errors");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("tb_padded_number_to_ascii: done, errors");
        $finish;
    end
endmodule
